/* design/r2d_pkg.sv */
// ----------------------------------------------------------------------------
// r2d_pkg
// Shared types, character constants and the digit decoder for the radix to
// decimal converter.
// ----------------------------------------------------------------------------
package r2d_pkg;

   // Default size of the decimal digit store
   localparam int DEC_DIGITS_DEF = 20;

   // ASCII character codes
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_SEVEN      = 8'h37;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_LOW_A      = 8'h61;
   localparam logic [7:0] CHAR_LOW_F      = 8'h66;
   localparam logic [7:0] LOWER_CASE_BIT  = 8'h20;
   localparam logic [7:0] HEX_LETTER_BASE = 8'h57;   // 'a' - 10

   // Divide by ten through the reciprocal, exact for values below 1029
   localparam logic [15:0] DIV10_MUL   = 16'd205;
   localparam int          DIV10_SHIFT = 11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_EMIT
   } r2d_state_type;

   typedef struct packed {
      logic [3:0] value;
      logic       bad;
   } r2d_digit_type;

   // Decode one character to its digit value in the selected radix
   function automatic r2d_digit_type digit_value(input logic [7:0] ch,
                                                 input logic       octal);
      r2d_digit_type r;
      logic [7:0]    low;
      low     = ch | LOWER_CASE_BIT;
      r.value = 4'd0;
      r.bad   = 1'b1;
      if (octal) begin
         // '0' has zero low bits, so the low 3 bits of ch - '0' are ch[2:0]
         r.value = {1'b0, ch[2:0]};
         r.bad   = !(ch inside {[CHAR_ZERO:CHAR_SEVEN]});
      end else if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
         r.value = 4'(ch - CHAR_ZERO);
         r.bad   = 1'b0;
      end else if (low inside {[CHAR_LOW_A:CHAR_LOW_F]}) begin
         r.value = 4'(low - HEX_LETTER_BASE);
         r.bad   = 1'b0;
      end
      return r;
   endfunction

endpackage

/* design/r2d_mac_cell.sv */
// ----------------------------------------------------------------------------
// r2d_mac_cell
// One decimal digit step: digit * radix + carry, split into a new decimal
// digit and the carry into the next place.
// ----------------------------------------------------------------------------
module r2d_mac_cell (
   input  logic [3:0] digit_i,
   input  logic [3:0] carry_i,
   input  logic       octal_i,
   output logic [3:0] digit_o,
   output logic [3:0] carry_o
);
   import r2d_pkg::*;

   logic [7:0]  sum;
   logic [15:0] prod;
   logic [3:0]  quot;
   logic [7:0]  rem;

   // Scale by 8 or 16 and add the incoming carry (at most 159)
   always_comb begin
      if (octal_i) begin
         sum = {1'b0, digit_i, 3'b000} + {4'b0000, carry_i};
      end else begin
         sum = {digit_i, 4'b0000} + {4'b0000, carry_i};
      end
   end

   // Quotient and remainder by ten
   assign prod    = {8'h00, sum} * DIV10_MUL;
   assign quot    = prod[DIV10_SHIFT+3:DIV10_SHIFT];
   assign rem     = sum - ({4'b0000, quot} * 8'd10);
   assign digit_o = rem[3:0];
   assign carry_o = quot;

endmodule

/* design/radix_to_decimal_converter.sv */
// ----------------------------------------------------------------------------
// radix_to_decimal_converter
// Accumulates hexadecimal or octal digit characters into a row of decimal
// digits and prints the value as ASCII decimal, most significant first.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata=char_in, tuser={start,octal}, tlast=end
//  rsp      out  rsp_tvalid/tready    tdata=decimal_char, tuser={bad,ovf}, tlast=final
//
//  Each character is taken while idle, then the single multiply-add cell walks
//  the digit shift register, one decimal place per step.
//  On a last character the emit pass adds DEC_DIGITS steps, one place per step;
//  a step waits while the output register is full and not taken.
//  Reset clears the digit store, flags and the output register; no clearing pass.
//  req_tready is high only while idle; the last result may still wait at rsp.
// ----------------------------------------------------------------------------
module radix_to_decimal_converter #(
   parameter int DEC_DIGITS = r2d_pkg::DEC_DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] char_in
   input  logic [1:0] req_tuser,    // [0] octal_mode, [1] start_of_number
   input  logic       req_tlast,    // end_of_number
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [5:0] decimal_char, [7:6] zero
   output logic [1:0] rsp_tuser,    // [0] overflow, [1] bad_char
   output logic       rsp_tlast     // final_digit
);
   import r2d_pkg::*;

   localparam int CntW = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;
   localparam logic [CntW-1:0] CntTop = CntW'(DEC_DIGITS - 1);

   r2d_state_type state_ff, state_in;

   logic [3:0]      digits_ff [DEC_DIGITS];
   logic [3:0]      digits_in [DEC_DIGITS];
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [3:0]      carry_ff, carry_in;
   logic            octal_ff, octal_in;
   logic            clear_ff, clear_in;
   logic            end_ff, end_in;
   logic            ovf_ff, ovf_in;
   logic            bad_ff, bad_in;
   logic            nonzero_ff, nonzero_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [5:0]      rsp_char_ff, rsp_char_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_ovf_ff, rsp_ovf_in;
   logic            rsp_bad_ff, rsp_bad_in;

   logic            accept;
   logic            mul_step;
   logic            emit_step;
   logic            out_free;
   r2d_digit_type   dec;
   logic [3:0]      cell_digit_in;
   logic [3:0]      cell_digit_out;
   logic [3:0]      cell_carry_out;
   logic [3:0]      top_digit;
   logic            emit_now;

   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign dec       = digit_value(req_tdata, req_tuser[0]);
   assign top_digit = digits_ff[DEC_DIGITS-1];
   assign emit_now  = (top_digit != 4'd0) || nonzero_ff || (cnt_ff == '0);

   // Multiply-add cell fed from the low end of the digit shift register
   assign cell_digit_in = clear_ff ? 4'd0 : digits_ff[0];

   r2d_mac_cell u_cell (
      .digit_i (cell_digit_in),
      .carry_i (carry_ff),
      .octal_i (octal_ff),
      .digit_o (cell_digit_out),
      .carry_o (cell_carry_out)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff == CntTop) begin
               state_in = end_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free && (cnt_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      mul_step   = 1'b0;
      emit_step  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_MUL:  mul_step   = 1'b1;
         ST_EMIT: emit_step  = out_free;
         default: req_tready = 1'b0;
      endcase
   end

   // Datapath: digit shift register, counters, flags and output register
   always_comb begin
      digits_in    = digits_ff;
      cnt_in       = cnt_ff;
      carry_in     = carry_ff;
      octal_in     = octal_ff;
      clear_in     = clear_ff;
      end_in       = end_ff;
      ovf_in       = ovf_ff;
      bad_in       = bad_ff;
      nonzero_in   = nonzero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_bad_in   = rsp_bad_ff;

      if (accept) begin
         // digit value rides in as the first carry
         carry_in = dec.value;
         octal_in = req_tuser[0];
         clear_in = req_tuser[1];
         end_in   = req_tlast;
         cnt_in   = '0;
         if (req_tuser[1]) begin
            ovf_in = 1'b0;
            bad_in = dec.bad;
         end else begin
            bad_in = bad_ff | dec.bad;
         end
      end

      if (mul_step) begin
         // rotate towards the low end, new digit enters at the top
         for (int i = 0; i < DEC_DIGITS - 1; i++) begin
            digits_in[i] = digits_ff[i+1];
         end
         digits_in[DEC_DIGITS-1] = cell_digit_out;
         carry_in = cell_carry_out;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CntTop) begin
            clear_in   = 1'b0;
            cnt_in     = CntTop;
            nonzero_in = 1'b0;
            if (cell_carry_out != 4'd0) begin
               ovf_in = 1'b1;
            end
         end
      end

      if (emit_step) begin
         // rotate towards the top end, most significant digit first
         for (int i = 1; i < DEC_DIGITS; i++) begin
            digits_in[i] = digits_ff[i-1];
         end
         digits_in[0] = top_digit;
         cnt_in       = cnt_ff - 1'b1;
         if (top_digit != 4'd0) begin
            nonzero_in = 1'b1;
         end
         if (emit_now) begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = 6'(CHAR_ZERO) + {2'b00, top_digit};
            rsp_last_in  = (cnt_ff == '0);
            rsp_ovf_in   = ovf_ff;
            rsp_bad_in   = bad_ff;
         end
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         clear_ff     <= 1'b0;
         end_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         bad_ff       <= 1'b0;
         nonzero_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEC_DIGITS; i++) begin
            digits_ff[i] <= 4'd0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clear_ff     <= clear_in;
         end_ff       <= end_in;
         ovf_ff       <= ovf_in;
         bad_ff       <= bad_in;
         nonzero_ff   <= nonzero_in;
         rsp_valid_ff <= rsp_valid_in;
         digits_ff    <= digits_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      carry_ff    <= carry_in;
      octal_ff    <= octal_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_char_ff};
   assign rsp_tuser  = {rsp_bad_ff, rsp_ovf_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A new result only appears from the emit pass
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result word loaded outside the emit pass");

   // Every accepted character starts a multiply pass
   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MUL))
      else $error("accepted word did not start a multiply pass");

   // The multiply pass ends after the top decimal place
   a_mul_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && cnt_ff == CntTop) |=> (state_ff != ST_MUL))
      else $error("multiply pass ran past the top digit");

   // Emitted characters are decimal digits
   a_rsp_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_char_ff >= 6'(CHAR_ZERO) && rsp_char_ff <= 6'(CHAR_NINE)))
      else $error("result is not a decimal digit");

   // A stalled emit pass does not advance
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_tready) |=> $stable(cnt_ff))
      else $error("emit pass advanced while the output was stalled");

endmodule

/* sim/radix_to_decimal_converter_tb.sv */
// ----------------------------------------------------------------------------
// radix_to_decimal_converter_tb
// Self-checking bench for the hex/octal to decimal converter. A table of
// directed words comes first. It covers the digit extremes, both letter
// cases, bad characters in both radices, a full 64-bit value and a wrap past
// the digit store. Random literals follow, some well-formed and some broken,
// with random idle gaps on both sides. Every decimal word leaving the block
// is compared with the typed answer of its table row or with a local model of the digit accumulator.
// ----------------------------------------------------------------------------
module radix_to_decimal_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import r2d_pkg::*;

   localparam int DEC_DIGITS   = DEC_DIGITS_DEF;
   localparam int NUM_DIRECTED = 26;
   localparam int TARGET_WORDS = 270;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 2 * DEC_DIGITS + 40;

   // one decimal word as it should leave the block
   typedef struct packed {
      logic [5:0] dec_char;
      logic       final_dig;
      logic       ovf;
      logic       bad;
   } dec_word_type;

   // one character word; an empty text means the model supplies the answer
   typedef struct {
      logic [7:0] ch;
      bit         oct;
      bit         st;
      bit         last;
      string      text;
      bit         ovf;
      bit         bad;
   } char_row_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;     // [7:0] char_in
   logic [1:0] req_tuser  = '0;     // [0] octal_mode, [1] start_of_number
   logic       req_tlast  = 1'b0;   // end_of_number
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [5:0] decimal_char, [7:6] zero
   logic [1:0] rsp_tuser;           // [0] overflow, [1] bad_char
   logic       rsp_tlast;           // final_digit

   radix_to_decimal_converter #(.DEC_DIGITS(DEC_DIGITS)) dut (.*);

   // model state: decimal accumulator, index 0 least significant
   logic [3:0] acc_digits [DEC_DIGITS];
   bit         acc_ovf;
   bit         acc_bad;

   dec_word_type  pending_digits[$];

   int fail_count      = 0;
   int words_sent      = 0;
   int numbers_emitted = 0;
   int numbers_ovf     = 0;
   int numbers_bad     = 0;
   int digits_checked  = 0;
   bit hold_request    = 0;
   bit steady_send     = 0;

   // directed words: extremes, letters of both cases, bad characters,
   // 2^64-1 filling the store exactly, then one more digit to wrap it
   char_row_type directed_rows [NUM_DIRECTED] = '{
      '{"0",   0, 1, 1, "0",  0, 0},
      '{"F",   0, 1, 1, "15", 0, 0},
      '{"a",   0, 1, 1, "10", 0, 0},
      '{"9",   0, 1, 1, "9",  0, 0},
      '{"g",   0, 1, 1, "0",  0, 1},
      '{8'hFF, 0, 1, 1, "0",  0, 1},
      '{8'h00, 1, 1, 1, "0",  0, 1},
      '{"7",   1, 1, 1, "7",  0, 0},
      '{"9",   1, 1, 1, "1",  0, 1},
      '{"f", 0, 1, 0, "", 0, 0}, '{"F", 0, 0, 0, "", 0, 0},
      '{"f", 0, 0, 0, "", 0, 0}, '{"F", 0, 0, 0, "", 0, 0},
      '{"f", 0, 0, 0, "", 0, 0}, '{"F", 0, 0, 0, "", 0, 0},
      '{"f", 0, 0, 0, "", 0, 0}, '{"F", 0, 0, 0, "", 0, 0},
      '{"f", 0, 0, 0, "", 0, 0}, '{"F", 0, 0, 0, "", 0, 0},
      '{"f", 0, 0, 0, "", 0, 0}, '{"F", 0, 0, 0, "", 0, 0},
      '{"f", 0, 0, 0, "", 0, 0}, '{"F", 0, 0, 0, "", 0, 0},
      '{"f", 0, 0, 0, "", 0, 0},
      '{"F", 0, 0, 1, "18446744073709551615", 0, 0},
      // continues without a start mark and wraps the store
      '{"f",   0, 0, 1, "",   0, 0}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // accumulate one character into the model and queue any decimal words
   function automatic void accumulate_char(logic [7:0] ch, bit oct, bit st,
                                           bit last, bit emit);
      logic [7:0]  folded;
      logic [7:0]  offset;
      int unsigned carry;
      int unsigned radix;
      int unsigned sum;
      int          top;
      bit          bad;
      folded = ch | LOWER_CASE_BIT;
      offset = ch - CHAR_ZERO;
      radix  = oct ? 8 : 16;
      if (st) begin
         foreach (acc_digits[i]) acc_digits[i] = '0;
         acc_ovf = 0;
         acc_bad = 0;
      end
      // digit decode
      if (oct) begin
         carry = 32'(offset[2:0]);
         bad   = !(ch >= CHAR_ZERO && ch <= CHAR_SEVEN);
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         carry = 32'(offset);
         bad   = 0;
      end else if (folded >= CHAR_LOW_A && folded <= CHAR_LOW_F) begin
         carry = 32'(8'(folded - HEX_LETTER_BASE));
         bad   = 0;
      end else begin
         carry = 0;
         bad   = 1;
      end
      if (bad) acc_bad = 1;
      // multiply-add with the carry rippling upward
      for (int i = 0; i < DEC_DIGITS; i++) begin
         sum           = 32'(acc_digits[i]) * radix + carry;
         acc_digits[i] = 4'(sum % 10);
         carry         = sum / 10;
      end
      if (carry != 0) acc_ovf = 1;
      if (!last) return;
      numbers_emitted++;
      if (acc_ovf) numbers_ovf++;
      if (acc_bad) numbers_bad++;
      if (!emit) return;
      // leading zeros dropped, zero itself prints as one digit
      top = 0;
      for (int i = DEC_DIGITS - 1; i > 0; i--) begin
         if (acc_digits[i] != 0) begin
            top = i;
            break;
         end
      end
      for (int i = top; i >= 0; i--)
         pending_digits.push_back('{dec_char: 6'(CHAR_ZERO + acc_digits[i]),
                                    final_dig: (i == 0), ovf: acc_ovf, bad: acc_bad});
   endfunction

   // offer one character word and hold it until taken
   task automatic send_char(input char_row_type row);
      int pick;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= row.ch;
      req_tuser  <= {row.st, row.oct};
      req_tlast  <= row.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      accumulate_char(row.ch, row.oct, row.st, row.last, row.text == "");
      // typed answer: one word per character of the text
      for (int i = 0; i < row.text.len(); i++)
         pending_digits.push_back('{dec_char: 6'(row.text[i]),
                                    final_dig: (i == row.text.len() - 1),
                                    ovf: row.ovf, bad: row.bad});
      // idle gap, mostly short
      pick = $urandom_range(0, 19);
      if (steady_send || pick < 12) gap = 0;
      else if (pick < 18)           gap = $urandom_range(1, 3);
      else                          gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // a random character, valid for the radix or anything at all
   function automatic logic [7:0] pick_char(bit oct, bit valid);
      int unsigned v;
      if (!valid) return 8'($urandom);
      if (oct) return CHAR_ZERO + 8'($urandom_range(0, 7));
      v = $urandom_range(0, 15);
      if (v < 10) return CHAR_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? CHAR_LOW_A : (CHAR_LOW_A & ~LOWER_CASE_BIT))
             + 8'(v - 10);
   endfunction

   // compare one decimal word with the oldest expectation
   task automatic check_digit();
      dec_word_type want;
      if (pending_digits.size() == 0) begin
         $error("unexpected decimal word %0d, nothing pending", rsp_tdata);
         fail_count++;
         return;
      end
      want = pending_digits.pop_front();
      digits_checked++;
      if (rsp_tdata[5:0] != want.dec_char) begin
         $error("decimal_char: expected %0d, got %0d", want.dec_char, rsp_tdata[5:0]);
         fail_count++;
      end
      if (rsp_tdata[7:6] != 2'b00) begin
         $error("tdata padding: expected 0, got %0d", rsp_tdata[7:6]);
         fail_count++;
      end
      if (rsp_tlast != want.final_dig) begin
         $error("final_digit: expected %0d, got %0d", want.final_dig, rsp_tlast);
         fail_count++;
      end
      if (rsp_tuser[0] != want.ovf) begin
         $error("overflow: expected %0d, got %0d", want.ovf, rsp_tuser[0]);
         fail_count++;
      end
      if (rsp_tuser[1] != want.bad) begin
         $error("bad_char: expected %0d, got %0d", want.bad, rsp_tuser[1]);
         fail_count++;
      end
   endtask

   // result side: check taken words, then choose next cycle's ready
   initial begin
      int  stall_left;
      int  pick;
      int  cycle_count;
      bit  steady_take;
      stall_left  = 0;
      cycle_count = 0;
      steady_take = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready) check_digit();
            cycle_count++;
            if (cycle_count % 256 == 0) steady_take = ($urandom_range(0, 3) == 0);
            if (hold_request) begin
               hold_request = 0;
               stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else if (steady_take) begin
               rsp_tready <= 1'b1;
            end else begin
               pick = $urandom_range(0, 9);
               if (pick < 6) begin
                  rsp_tready <= 1'b1;
               end else begin
                  stall_left = (pick < 9) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                  rsp_tready <= 1'b0;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      char_row_type row;
      int        number_idx;
      int        kind;
      int        len;
      bit        oct;
      foreach (acc_digits[i]) acc_digits[i] = '0;
      acc_ovf = 0;
      acc_bad = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_char(directed_rows[i]);

      // random literals
      number_idx = 0;
      row.text   = "";
      row.ovf    = 0;
      row.bad    = 0;
      while (words_sent < TARGET_WORDS) begin
         number_idx++;
         steady_send = ($urandom_range(0, 3) == 0);
         // receiver holds off while words keep coming
         if (number_idx == 8) hold_request = 1;
         // sender waits for every pending word to drain
         if (number_idx == 30) begin
            req_tvalid <= 1'b0;
            while (pending_digits.size() != 0) @(posedge clock);
         end
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            // noise word: every field random
            row.ch   = 8'($urandom);
            row.oct  = 1'($urandom_range(0, 1));
            row.st   = 1'($urandom_range(0, 1));
            row.last = 1'($urandom_range(0, 1));
            send_char(row);
         end else begin
            oct = ($urandom_range(0, 2) == 0);
            if (kind <= 2) len = oct ? $urandom_range(21, 24) : $urandom_range(16, 18);
            else           len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               row.ch   = pick_char(oct, $urandom_range(0, 11) != 0);
               row.oct  = oct;
               // now and then a literal continues the previous value
               row.st   = (i == 0) && ($urandom_range(0, 9) != 0);
               row.last = (i == len - 1);
               send_char(row);
            end
         end
      end
      req_tvalid <= 1'b0;

      // drain
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d character words; %0d numbers converted, %0d decimal words checked",
               words_sent, numbers_emitted, digits_checked);
      $display("Numbers that wrapped the store: %0d, with bad characters: %0d",
               numbers_ovf, numbers_bad);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
